FILE: rtl/tcac_pkg.sv
// shared types, constants and helper functions for the touch coordinate core
package tcac_pkg;

    // parameter defaults
    localparam int SAMPLES_DEF      = 10;
    localparam int PANEL_WIDTH_DEF  = 160;
    localparam int PANEL_HEIGHT_DEF = 128;

    // datapath widths, sized for the full parameter range
    localparam int RAW_W      = 16;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 4;
    localparam int PIX_W      = 13;
    localparam int OFS_W      = 15;
    localparam int DIV_W      = 27;
    localparam int DEN_W      = 16;
    localparam int ITER_W     = 5;
    localparam int COORD_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RCP_W      = 28;
    localparam int MUL_W      = DIV_W + RCP_W;

    // raw converter window
    localparam logic [RAW_W-1:0] RAW_X_MIN = 16'd1500;
    localparam logic [RAW_W-1:0] RAW_X_MAX = 16'd31000;
    localparam logic [RAW_W-1:0] RAW_Y_MIN = 16'd3276;
    localparam logic [RAW_W-1:0] RAW_Y_MAX = 16'd30110;
    localparam logic [DEN_W-1:0] X_SPAN    = DEN_W'(RAW_X_MAX - RAW_X_MIN);
    localparam logic [DEN_W-1:0] Y_SPAN    = DEN_W'(RAW_Y_MAX - RAW_Y_MIN);

    // reciprocals for the pixel scaling, exact for any numerator below 2^DIV_W
    localparam int SCL_SHIFT = 42;
    localparam logic [RCP_W-1:0] X_RCP =
        RCP_W'(((64'd1 << SCL_SHIFT) + 64'(X_SPAN) - 64'd1) / 64'(X_SPAN));
    localparam logic [RCP_W-1:0] Y_RCP =
        RCP_W'(((64'd1 << SCL_SHIFT) + 64'(Y_SPAN) - 64'd1) / 64'(Y_SPAN));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN_DIVISOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABORT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_GAIN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_POST,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_AVG_X,
        PH_AVG_Y,
        PH_SCL_X,
        PH_SCL_Y,
        PH_COR_X,
        PH_COR_Y
    } phase_t;

    // clamp an average into its window and return the distance from the low edge
    function automatic logic [OFS_W-1:0] clamp_offset(
        input logic [RAW_W-1:0] avg,
        input logic [RAW_W-1:0] lo,
        input logic [RAW_W-1:0] hi
    );
        logic [RAW_W-1:0] c;
        logic [RAW_W-1:0] d;
        if (avg < lo)
        begin
            c = lo;
        end
        else if (avg > hi)
        begin
            c = hi;
        end
        else
        begin
            c = avg;
        end
        d = c - lo;
        return d[OFS_W-1:0];
    endfunction

    // apply quotient sign, add offset, saturate to int16
    function automatic logic signed [COORD_W-1:0] correct_sat(
        input logic [PIX_W-1:0]          q,
        input logic                      neg,
        input logic signed [COORD_W-1:0] off
    );
        logic signed [COORD_W+1:0] v;
        logic signed [COORD_W+1:0] s;
        logic signed [COORD_W-1:0] r;
        v = $signed((COORD_W+2)'(q));
        if (neg)
        begin
            v = -v;
        end
        s = v + (COORD_W+2)'(off);
        if (s > (COORD_W+2)'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (s < -(COORD_W+2)'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/touch_coordinate_average_calibrate_core.sv
// touch coordinate averaging, window scaling and gain/offset calibration core
//
// input channel (in_valid/in_ready) carries pen_down, sample_x, sample_y.
// output channel (out_valid/out_ready) carries status, coord_x, coord_y.
// cfg_we/cfg_index/cfg_data write the calibration registers.
//
// a pen-down transfer is summed into the burst; the transfer that completes
// a burst of SAMPLES starts a sequence: average x and y, then scale x and y,
// each a constant divide on one shared reciprocal multiplier (load, multiply,
// post), then the gain divides for x and y on one restoring divider (load,
// 27 quotient steps, post). a gain divide is skipped when calibration is off
// or that gain is zero. a pen-up during a burst yields an abort result
// through the emit state; a pen-up with no burst yields nothing. in_ready is
// high only while the sequencer is idle. results sit in an output register;
// a stalled receiver holds that register and the core keeps accepting
// samples until a new result needs the register.
// reset clears the burst, the sequencer and the calibration registers (gains
// to one, offsets to zero, calibration off).
module touch_coordinate_average_calibrate_core
    import tcac_pkg::*;
#(
    parameter int SAMPLES      = SAMPLES_DEF,
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        pen_down,
    input  logic [RAW_W-1:0]            sample_x,
    input  logic [RAW_W-1:0]            sample_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [STATUS_W-1:0]         status,
    output logic signed [COORD_W-1:0]   coord_x,
    output logic signed [COORD_W-1:0]   coord_y,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    // reciprocal of SAMPLES, exact for any 20-bit sum
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES);
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    // configuration
    logic                       calib_reg;
    logic signed [COORD_W-1:0]  x_gain_reg;
    logic signed [COORD_W-1:0]  x_off_reg;
    logic signed [COORD_W-1:0]  y_gain_reg;
    logic signed [COORD_W-1:0]  y_off_reg;

    // control
    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic [SUM_W-1:0]           sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]           sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;

    // datapath
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [DEN_W-1:0]           rem_reg, rem_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic [MUL_W-1:0]           mul_reg, mul_next;
    logic [OFS_W-1:0]           offx_reg, offx_next;
    logic [OFS_W-1:0]           offy_reg, offy_next;
    logic [PIX_W-1:0]           cx_reg, cx_next;
    logic [PIX_W-1:0]           cy_reg, cy_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic signed [COORD_W-1:0]  res_x_reg, res_x_next;
    logic signed [COORD_W-1:0]  res_y_reg, res_y_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [COORD_W-1:0]  out_x_reg, out_x_next;
    logic signed [COORD_W-1:0]  out_y_reg, out_y_next;

    // shared helpers
    logic [CNT_W:0]             cnt_inc;
    logic                       burst_done;
    logic                       abort_hit;
    logic                       skip_x;
    logic                       skip_y;
    logic [DEN_W-1:0]           x_gain_mag;
    logic [DEN_W-1:0]           y_gain_mag;
    logic [DEN_W:0]             trial;
    logic [DEN_W:0]             diff;
    logic                       ge;
    logic [2*DEN_W-1:0]         prod_x;
    logic [2*DEN_W-1:0]         prod_y;
    logic [RCP_W-1:0]           rcp_sel;
    logic                       emit_fire;

    assign cnt_inc    = (CNT_W+1)'(count_reg) + (CNT_W+1)'(1);
    assign burst_done = cnt_inc >= (CNT_W+1)'(SAMPLES);
    assign abort_hit  = !pen_down && (count_reg != '0);
    assign skip_x     = !calib_reg || (x_gain_reg == '0);
    assign skip_y     = !calib_reg || (y_gain_reg == '0);
    assign x_gain_mag = x_gain_reg[COORD_W-1] ? DEN_W'(-x_gain_reg) : DEN_W'(x_gain_reg);
    assign y_gain_mag = y_gain_reg[COORD_W-1] ? DEN_W'(-y_gain_reg) : DEN_W'(y_gain_reg);

    // one restoring divide step
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - (DEN_W+1)'(den_reg);
    assign ge    = trial >= (DEN_W+1)'(den_reg);

    assign prod_x = (2*DEN_W)'(offx_reg) * (2*DEN_W)'(PANEL_WIDTH);
    assign prod_y = (2*DEN_W)'(offy_reg) * (2*DEN_W)'(PANEL_HEIGHT);

    // constant divisor of the current phase, as a reciprocal
    assign rcp_sel = (phase_reg == PH_SCL_X) ? X_RCP :
                     (phase_reg == PH_SCL_Y) ? Y_RCP : AVG_RCP;

    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign coord_x   = out_x_reg;
    assign coord_y   = out_y_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg  <= 1'b0;
            x_gain_reg <= 16'sd1;
            x_off_reg  <= '0;
            y_gain_reg <= 16'sd1;
            y_off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CALIB_ENABLE:   calib_reg  <= cfg_data[0];
                REG_X_GAIN_DIVISOR: x_gain_reg <= $signed(cfg_data);
                REG_X_OFFSET:       x_off_reg  <= $signed(cfg_data);
                REG_Y_GAIN_DIVISOR: y_gain_reg <= $signed(cfg_data);
                REG_Y_OFFSET:       y_off_reg  <= $signed(cfg_data);
                default:            ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (abort_hit)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (pen_down && burst_done)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (phase_reg == PH_COR_X && skip_x)
                begin
                    state_next = ST_LOAD;
                end
                else if (phase_reg == PH_COR_Y && skip_y)
                begin
                    state_next = ST_EMIT;
                end
                else if (phase_reg == PH_COR_X || phase_reg == PH_COR_Y)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_POST;
            end
            ST_DIV:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = (phase_reg == PH_COR_Y) ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next      = phase_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        count_next      = count_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        iter_next       = iter_reg;
        mul_next        = mul_reg;
        offx_next       = offx_reg;
        offy_next       = offy_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (abort_hit)
                    begin
                        sum_x_next      = '0;
                        sum_y_next      = '0;
                        count_next      = '0;
                        res_status_next = STATUS_ABORT;
                        res_x_next      = '0;
                        res_y_next      = '0;
                    end
                    else if (pen_down)
                    begin
                        sum_x_next = sum_x_reg + SUM_W'(sample_x);
                        sum_y_next = sum_y_reg + SUM_W'(sample_y);
                        if (burst_done)
                        begin
                            count_next      = '0;
                            phase_next      = PH_AVG_X;
                            res_status_next = STATUS_OK;
                        end
                        else
                        begin
                            count_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                rem_next  = '0;
                iter_next = ITER_W'(DIV_W - 1);
                unique case (phase_reg)
                    PH_AVG_X:
                    begin
                        quo_next = DIV_W'(sum_x_reg);
                    end
                    PH_AVG_Y:
                    begin
                        quo_next = DIV_W'(sum_y_reg);
                    end
                    PH_SCL_X:
                    begin
                        quo_next = prod_x[DIV_W-1:0];
                    end
                    PH_SCL_Y:
                    begin
                        quo_next = prod_y[DIV_W-1:0];
                    end
                    PH_COR_X:
                    begin
                        quo_next = DIV_W'(cx_reg);
                        den_next = x_gain_mag;
                        if (skip_x)
                        begin
                            // uncorrected value passes, flagged when calibration is on and the gain is zero
                            res_x_next = COORD_W'(cx_reg);
                            phase_next = PH_COR_Y;
                            if (calib_reg)
                            begin
                                res_status_next = STATUS_ZERO_GAIN;
                            end
                        end
                    end
                    PH_COR_Y:
                    begin
                        quo_next = DIV_W'(cy_reg);
                        den_next = y_gain_mag;
                        if (skip_y)
                        begin
                            res_y_next = COORD_W'(cy_reg);
                            if (calib_reg)
                            begin
                                res_status_next = STATUS_ZERO_GAIN;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL:
            begin
                mul_next = MUL_W'(quo_reg) * MUL_W'(rcp_sel);
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next  = {quo_reg[DIV_W-2:0], ge};
                iter_next = iter_reg - ITER_W'(1);
            end
            ST_POST:
            begin
                unique case (phase_reg)
                    PH_AVG_X:
                    begin
                        offx_next  = clamp_offset(mul_reg[AVG_SHIFT +: RAW_W], RAW_X_MIN,
                                                  RAW_X_MAX);
                        phase_next = PH_AVG_Y;
                    end
                    PH_AVG_Y:
                    begin
                        offy_next  = clamp_offset(mul_reg[AVG_SHIFT +: RAW_W], RAW_Y_MIN,
                                                  RAW_Y_MAX);
                        sum_x_next = '0;
                        sum_y_next = '0;
                        phase_next = PH_SCL_X;
                    end
                    PH_SCL_X:
                    begin
                        cx_next    = mul_reg[SCL_SHIFT +: PIX_W];
                        phase_next = PH_SCL_Y;
                    end
                    PH_SCL_Y:
                    begin
                        cy_next    = mul_reg[SCL_SHIFT +: PIX_W];
                        phase_next = PH_COR_X;
                    end
                    PH_COR_X:
                    begin
                        res_x_next = correct_sat(quo_reg[PIX_W-1:0], x_gain_reg[COORD_W-1],
                                                 x_off_reg);
                        phase_next = PH_COR_Y;
                    end
                    PH_COR_Y:
                    begin
                        res_y_next = correct_sat(quo_reg[PIX_W-1:0], y_gain_reg[COORD_W-1],
                                                 y_off_reg);
                    end
                    default: ;
                endcase
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_AVG_X;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        iter_reg       <= iter_next;
        mul_reg        <= mul_next;
        offx_reg       <= offx_next;
        offy_reg       <= offy_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        out_status_reg <= out_status_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
    end

    // the burst counter never holds a full burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(count_reg) < (CNT_W+1)'(SAMPLES))
        else $error("burst count reached SAMPLES");

    // the divider never runs on a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("divide step with zero divisor");

    // a pen-up inside a burst goes straight to an abort result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && abort_hit) |=>
            (state_reg == ST_EMIT && res_status_reg == STATUS_ABORT && count_reg == '0))
        else $error("abort transfer not reported");

    // a new result only comes from the emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside emit");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the touch coordinate averaging and calibration core
module tb_top;
    import tcac_pkg::*;

    localparam int TOUCH_SAMPLES = 10;
    localparam int PANEL_W       = 160;
    localparam int PANEL_H       = 128;
    localparam int WIN_X_LO      = 1500;
    localparam int WIN_X_HI      = 31000;
    localparam int WIN_Y_LO      = 3276;
    localparam int WIN_Y_HI      = 30110;

    localparam int SETTLE_CYCLES   = 250;
    localparam int HOLD_CYCLES     = 3000;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DIRECTED_ROWS   = 5;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } coord_result_t;

    typedef struct packed {
        logic          pen;
        logic [15:0]   sx;
        logic [15:0]   sy;
        logic [4:0]    reps;
        logic          typed;
        coord_result_t res;
    } touch_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      pen_down  = 1'b0;
    logic [RAW_W-1:0]          sample_x  = '0;
    logic [RAW_W-1:0]          sample_y  = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;

    // predictor copy of burst state and calibration registers
    logic [SUM_W-1:0]          acc_x     = '0;
    logic [SUM_W-1:0]          acc_y     = '0;
    logic [CNT_W-1:0]          burst_cnt = '0;
    logic                      cal_on    = 1'b0;
    logic signed [15:0]        gain_x    = 16'sd1;
    logic signed [15:0]        ofs_x     = 16'sd0;
    logic signed [15:0]        gain_y    = 16'sd1;
    logic signed [15:0]        ofs_y     = 16'sd0;

    coord_result_t expected_coords[$];
    coord_result_t next_coord;
    touch_row_t    directed_rows[DIRECTED_ROWS];

    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int aborts_seen     = 0;
    int zero_gain_seen  = 0;
    int mismatches      = 0;

    touch_coordinate_average_calibrate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pen_down  (pen_down),
        .sample_x  (sample_x),
        .sample_y  (sample_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // clamp into the raw window, then map to pixels with truncation
    function automatic int unsigned to_pixels(input int unsigned avg, input int unsigned lo,
                                              input int unsigned hi, input int unsigned span);
        int unsigned a;
        a = avg;
        if (a < lo)
        begin
            a = lo;
        end
        if (a > hi)
        begin
            a = hi;
        end
        return ((a - lo) * span) / (hi - lo);
    endfunction

    function automatic int apply_gain(input int v, input int div, input int off);
        int r;
        r = v / div + off;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r;
    endfunction

    function automatic bit predict_touch(input logic pen, input logic [RAW_W-1:0] sx,
                                         input logic [RAW_W-1:0] sy,
                                         output coord_result_t res);
        int unsigned next_cnt;
        int          cx;
        int          cy;
        res = '0;
        res.status = STATUS_OK;
        if (!pen)
        begin
            if (burst_cnt == 0)
            begin
                return 1'b0;
            end
            acc_x = '0;
            acc_y = '0;
            burst_cnt = '0;
            res.status = STATUS_ABORT;
            return 1'b1;
        end
        acc_x = acc_x + SUM_W'(sx);
        acc_y = acc_y + SUM_W'(sy);
        next_cnt = int'(burst_cnt) + 1;
        if (next_cnt < TOUCH_SAMPLES)
        begin
            burst_cnt = CNT_W'(next_cnt);
            return 1'b0;
        end
        cx = int'(to_pixels(int'(acc_x) / TOUCH_SAMPLES, WIN_X_LO, WIN_X_HI, PANEL_W));
        cy = int'(to_pixels(int'(acc_y) / TOUCH_SAMPLES, WIN_Y_LO, WIN_Y_HI, PANEL_H));
        acc_x = '0;
        acc_y = '0;
        burst_cnt = '0;
        if (cal_on)
        begin
            // a zero divisor leaves that axis uncorrected, offset included
            if (gain_x != 0)
            begin
                cx = apply_gain(cx, gain_x, ofs_x);
            end
            else
            begin
                res.status = STATUS_ZERO_GAIN;
            end
            if (gain_y != 0)
            begin
                cy = apply_gain(cy, gain_y, ofs_y);
            end
            else
            begin
                res.status = STATUS_ZERO_GAIN;
            end
        end
        res.cx = cx[COORD_W-1:0];
        res.cy = cy[COORD_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [15:0] jittered(input logic [15:0] c);
        int v;
        v = int'(c) + int'($urandom_range(600)) - 300;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return v[15:0];
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_CALIB_ENABLE:   cal_on = data[0];
            REG_X_GAIN_DIVISOR: gain_x = data;
            REG_X_OFFSET:       ofs_x = data;
            REG_Y_GAIN_DIVISOR: gain_y = data;
            REG_Y_OFFSET:       ofs_y = data;
            default:            ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_calibration(input bit en, input int gx, input int ox,
                                   input int gy, input int oy);
        // writes past the last register must leave everything alone
        cfg_write(CFG_IDX_W'(REG_Y_OFFSET + 3'd1 + 3'($urandom_range(2))), 16'($urandom));
        cfg_write(REG_CALIB_ENABLE, {15'd0, en});
        cfg_write(REG_X_GAIN_DIVISOR, 16'(gx));
        cfg_write(REG_X_OFFSET, 16'(ox));
        cfg_write(REG_Y_GAIN_DIVISOR, 16'(gy));
        cfg_write(REG_Y_OFFSET, 16'(oy));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input logic pen, input logic [15:0] sx, input logic [15:0] sy,
                             input bit typed, input coord_result_t typed_res);
        coord_result_t res;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pen_down <= pen;
        sample_x <= sx;
        sample_y <= sy;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (predict_touch(pen, sx, sy, res))
        begin
            expected_coords.push_back(typed ? typed_res : res);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // called at a falling edge; returns at a falling edge with nothing outstanding
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_coords.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly whole bursts with random content, some aborted bursts and stray pen-ups
    task automatic run_bursts(input int n);
        int          counted;
        int          kind;
        int          k;
        int          i;
        bit          wide;
        logic [15:0] cx0;
        logic [15:0] cy0;
        counted = 0;
        while (counted < n)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                send_item(1'b0, 16'($urandom), 16'($urandom), 1'b0, '0);
            end
            else
            begin
                k = (kind < 25) ? $urandom_range(TOUCH_SAMPLES - 1, 1) : TOUCH_SAMPLES;
                wide = ($urandom_range(3) == 0);
                cx0 = 16'($urandom_range(34000));
                cy0 = 16'($urandom_range(34000));
                for (i = 0; i < k; i++)
                begin
                    send_item(1'b1, wide ? 16'($urandom) : jittered(cx0),
                              wide ? 16'($urandom) : jittered(cy0), 1'b0, '0);
                end
                if (k < TOUCH_SAMPLES)
                begin
                    send_item(1'b0, 16'($urandom), 16'($urandom), 1'b0, '0);
                    k++;
                end
                counted += k;
            end
        end
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_stall_pct == 0)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_coords.size() == 0)
            begin
                $error("unexpected result: status %0d coord_x %0d coord_y %0d",
                       status, coord_x, coord_y);
                mismatches++;
            end
            else
            begin
                next_coord = expected_coords.pop_front();
                results_checked++;
                if (status == STATUS_ABORT)
                begin
                    aborts_seen++;
                end
                if (status == STATUS_ZERO_GAIN)
                begin
                    zero_gain_seen++;
                end
                if (status !== next_coord.status)
                begin
                    $error("status: expected %0d, got %0d", next_coord.status, status);
                    mismatches++;
                end
                if (coord_x !== next_coord.cx)
                begin
                    $error("coord_x: expected %0d, got %0d", next_coord.cx, coord_x);
                    mismatches++;
                end
                if (coord_y !== next_coord.cy)
                begin
                    $error("coord_y: expected %0d, got %0d", next_coord.cy, coord_y);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int p;
        // full scale, below both windows (lower clamp on both axes), an aborted burst, a stray pen-up
        directed_rows[0] = '{1'b1, 16'hffff, 16'hffff, 5'(TOUCH_SAMPLES), 1'b1,
                             coord_result_t'{STATUS_OK, 16'sd160, 16'sd128}};
        directed_rows[1] = '{1'b1, 16'h0000, 16'h0000, 5'(TOUCH_SAMPLES), 1'b1,
                             coord_result_t'{STATUS_OK, 16'sd0, 16'sd0}};
        directed_rows[2] = '{1'b1, 16'h8000, 16'h7fff, 5'd3, 1'b0, '0};
        directed_rows[3] = '{1'b0, 16'hffff, 16'hffff, 5'd1, 1'b1,
                             coord_result_t'{STATUS_ABORT, 16'sd0, 16'sd0}};
        directed_rows[4] = '{1'b0, 16'h1234, 16'h4321, 5'd1, 1'b0, '0};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            repeat (directed_rows[r].reps)
            begin
                send_item(directed_rows[r].pen, directed_rows[r].sx, directed_rows[r].sy,
                          directed_rows[r].typed, directed_rows[r].res);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_and_settle();
            case (p)
                0: ; // reset calibration: off, unit gains
                1: set_calibration(1'b1, 1, 0, 1, 0);
                2: set_calibration(1'b1, -1, 32767, 1, 32767);
                3: set_calibration(1'b1, 0, 1234, 3, -50);
                4: set_calibration(1'b1, -32768, -32768, 0, 32767);
                5: set_calibration(1'b1, 32767, -32768, -1, -32768);
                6: set_calibration(1'b0, 0, 500, 0, -500);
                7: set_calibration(1'b1, 0, 32767, 0, -32768);
                default: set_calibration(1'b1, int'($urandom_range(8)) - 4,
                                         int'($urandom_range(65535)) - 32768,
                                         int'($urandom_range(8)) - 4,
                                         int'($urandom_range(65535)) - 32768);
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            if (p == 2)
            begin
                // long receiver hold-off so results back up and the input stalls
                hold_requests++;
            end
            run_bursts(ITEMS_PER_PHASE);
        end

        in_valid <= 1'b0;
        while (expected_coords.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d input transfers over %0d calibration settings, with idle and stall mixes",
                 items_sent, RANDOM_PHASES);
        $display("run: %0d results checked (%0d aborts, %0d zero-gain), %0d mismatches",
                 results_checked, aborts_seen, zero_gain_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
